/* rtl/alr_pkg.sv */
// ----------------------------------------------------------------------------
// alr_pkg
// Shared constants, codes and control structs of the array list engine.
// ----------------------------------------------------------------------------
package alr_pkg;

   localparam int DEPTH_DEFAULT = 1024;

   localparam int DATA_W = 32;
   localparam int POS_W  = 11;
   localparam int OUT_W  = 11;

   // request codes
   localparam logic [2:0] REQ_INSERT = 3'd0;
   localparam logic [2:0] REQ_DELETE = 3'd1;
   localparam logic [2:0] REQ_READ   = 3'd2;
   localparam logic [2:0] REQ_FIND   = 3'd3;
   localparam logic [2:0] REQ_REMOVE = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic latch;    // capture the request
      logic setup;    // check request, load walk pointers
      logic issue;    // issue one memory read of the walk
      logic commit;   // update count, load result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic err;         // request fails its checks
      logic walk_empty;  // no entries to walk
      logic walk_last;   // the read issued in this step is the last of the walk
   } stat_type;

endpackage

/* rtl/alr_ram.sv */
// ----------------------------------------------------------------------------
// alr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module alr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/alr_ctrl.sv */
// ----------------------------------------------------------------------------
// alr_ctrl
// Request sequencer: setup, memory walk, drain of the last read, commit.
// ----------------------------------------------------------------------------
module alr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  alr_pkg::stat_type stat,
   output alr_pkg::cmd_type  cmd
);

   typedef enum logic [2:0] {
      IDLE,
      SETUP,
      WALK,
      DRAIN,
      DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (start) begin
               state_in = SETUP;
            end
         end
         SETUP: begin
            if (stat.err || stat.walk_empty) begin
               state_in = DONE;
            end else begin
               state_in = WALK;
            end
         end
         WALK: begin
            if (stat.walk_last) begin
               state_in = DRAIN;
            end
         end
         DRAIN: state_in = DONE;
         DONE:  state_in = IDLE;
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != IDLE);
   assign cmd.latch  = start && (state_ff == IDLE);
   assign cmd.setup  = (state_ff == SETUP);
   assign cmd.issue  = (state_ff == WALK);
   assign cmd.commit = (state_ff == DONE);

endmodule

/* rtl/alr_dpath.sv */
// ----------------------------------------------------------------------------
// alr_dpath
// Request registers, entry count, walk pointers and result registers.
// Drives the entry memory: one read per walk step, at most one write per step.
// ----------------------------------------------------------------------------
module alr_dpath #(
   parameter int DEPTH = alr_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  alr_pkg::cmd_type                  cmd,
   output alr_pkg::stat_type                 stat,
   input  logic [2:0]                        req_type,
   input  logic [alr_pkg::POS_W-1:0]         req_position,
   input  logic signed [alr_pkg::DATA_W-1:0] req_item_value,
   output logic                              mem_wr_en,
   output logic [$clog2(DEPTH)-1:0]          mem_wr_addr,
   output logic [alr_pkg::DATA_W-1:0]        mem_wr_data,
   output logic                              mem_rd_en,
   output logic [$clog2(DEPTH)-1:0]          mem_rd_addr,
   input  logic [alr_pkg::DATA_W-1:0]        mem_rd_data,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [alr_pkg::DATA_W-1:0] rsp_read_data,
   output logic signed [alr_pkg::OUT_W-1:0]  rsp_found_index,
   output logic [alr_pkg::OUT_W-1:0]         rsp_list_length,
   output logic [alr_pkg::OUT_W-1:0]         rsp_removed_count
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > alr_pkg::POS_W) ? CNT_W : alr_pkg::POS_W;
   localparam int OW    = alr_pkg::OUT_W;

   // request
   logic [2:0]                 op_ff;
   logic [alr_pkg::POS_W-1:0]  pos_ff;
   logic [alr_pkg::DATA_W-1:0] val_ff;

   // list state
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // walk
   logic [AW-1:0]    rd_ptr_ff;
   logic [CNT_W-1:0] remain_ff;
   logic             rvalid_ff;
   logic [AW-1:0]    raddr_d_ff;
   logic [AW-1:0]    wr_ptr_ff;
   logic [CNT_W-1:0] removed_ff;
   logic             hit_ff;
   logic [AW-1:0]    found_addr_ff;
   logic [alr_pkg::DATA_W-1:0] rdata_ff;
   logic [1:0]       status_ff;

   // result registers
   logic                       rsp_valid_ff;
   logic [1:0]                 rsp_status_ff;
   logic [alr_pkg::DATA_W-1:0] rsp_read_data_ff;
   logic [OW-1:0]              rsp_found_ff;
   logic [OW-1:0]              rsp_length_ff;
   logic [OW-1:0]              rsp_removed_ff;

   logic [CMP_W-1:0] pos_cmp;
   logic [CMP_W-1:0] cnt_cmp;
   logic [CMP_W-1:0] depth_cmp;
   logic [1:0]       status_chk;
   logic [CMP_W-1:0] walk_len;
   logic [CMP_W-1:0] start_ptr;
   logic             step_down;
   logic             match;
   logic [AW+OW-1:0]    found_wide;
   logic [CNT_W+OW-1:0] length_wide;
   logic [CNT_W+OW-1:0] removed_wide;
   logic [OW-1:0]       removed_out;

   assign pos_cmp   = CMP_W'(pos_ff);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign depth_cmp = CMP_W'(DEPTH);

   // position and capacity checks, walk length and first address
   always_comb begin
      status_chk = alr_pkg::ST_OK;
      walk_len   = '0;
      start_ptr  = '0;
      case (op_ff)
         alr_pkg::REQ_INSERT: begin
            if (pos_cmp > cnt_cmp) begin
               status_chk = alr_pkg::ST_RANGE;
            end else if (cnt_cmp >= depth_cmp) begin
               status_chk = alr_pkg::ST_FULL;
            end
            walk_len  = cnt_cmp - pos_cmp;
            start_ptr = cnt_cmp - CMP_W'(1);
         end
         alr_pkg::REQ_DELETE: begin
            if (pos_cmp >= cnt_cmp) begin
               status_chk = alr_pkg::ST_RANGE;
            end
            walk_len  = cnt_cmp - pos_cmp - CMP_W'(1);
            start_ptr = pos_cmp + CMP_W'(1);
         end
         alr_pkg::REQ_READ: begin
            if (pos_cmp >= cnt_cmp) begin
               status_chk = alr_pkg::ST_RANGE;
            end
            walk_len  = CMP_W'(1);
            start_ptr = pos_cmp;
         end
         alr_pkg::REQ_FIND, alr_pkg::REQ_REMOVE: begin
            walk_len = cnt_cmp;
         end
         default: begin
            walk_len = '0;
         end
      endcase
   end

   assign stat.err        = (status_chk != alr_pkg::ST_OK);
   assign stat.walk_empty = (walk_len == '0);
   assign stat.walk_last  = (remain_ff == CNT_W'(1));

   // insert walks from the top down, everything else walks up
   assign step_down = (op_ff == alr_pkg::REQ_INSERT);
   assign match     = (mem_rd_data == val_ff);

   assign mem_rd_en   = cmd.issue;
   assign mem_rd_addr = rd_ptr_ff;

   // memory write: shift moves and remove compaction during the walk, new entry at commit
   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = raddr_d_ff;
      mem_wr_data = mem_rd_data;
      if (cmd.commit) begin
         mem_wr_en   = (op_ff == alr_pkg::REQ_INSERT) && (status_ff == alr_pkg::ST_OK);
         mem_wr_addr = AW'(pos_ff);
         mem_wr_data = val_ff;
      end else if (rvalid_ff) begin
         case (op_ff)
            alr_pkg::REQ_INSERT: begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = raddr_d_ff + AW'(1);
            end
            alr_pkg::REQ_DELETE: begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = raddr_d_ff - AW'(1);
            end
            alr_pkg::REQ_REMOVE: begin
               mem_wr_en   = !match;
               mem_wr_addr = wr_ptr_ff;
            end
            default: begin
               mem_wr_en = 1'b0;
            end
         endcase
      end
   end

   // length after the request
   always_comb begin
      count_in = count_ff;
      if (status_ff == alr_pkg::ST_OK) begin
         case (op_ff)
            alr_pkg::REQ_INSERT: count_in = count_ff + CNT_W'(1);
            alr_pkg::REQ_DELETE: count_in = count_ff - CNT_W'(1);
            alr_pkg::REQ_REMOVE: count_in = CNT_W'(wr_ptr_ff) + CNT_W'(0)
                                            + ((removed_ff == '0 && count_ff == CNT_W'(DEPTH))
                                               ? CNT_W'(DEPTH) - CNT_W'(wr_ptr_ff) : CNT_W'(0));
            default:             count_in = count_ff;
         endcase
      end
   end

   assign found_wide   = {{OW{1'b0}}, found_addr_ff};
   assign length_wide  = {{OW{1'b0}}, count_in};
   assign removed_wide = {{OW{1'b0}}, removed_ff};

   always_comb begin
      case (op_ff)
         alr_pkg::REQ_DELETE: removed_out = (status_ff == alr_pkg::ST_OK) ? OW'(1) : '0;
         alr_pkg::REQ_REMOVE: removed_out = removed_wide[OW-1:0];
         default:             removed_out = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rvalid_ff    <= cmd.issue;
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit) begin
            count_ff <= count_in;
         end
      end

      if (cmd.latch) begin
         op_ff  <= req_type;
         pos_ff <= req_position;
         val_ff <= req_item_value;
      end

      if (cmd.setup) begin
         status_ff  <= status_chk;
         rd_ptr_ff  <= AW'(start_ptr);
         remain_ff  <= CNT_W'(walk_len);
         wr_ptr_ff  <= '0;
         removed_ff <= '0;
         hit_ff     <= 1'b0;
         rdata_ff   <= '0;
      end else if (cmd.issue) begin
         rd_ptr_ff <= step_down ? rd_ptr_ff - AW'(1) : rd_ptr_ff + AW'(1);
         remain_ff <= remain_ff - CNT_W'(1);
      end

      if (cmd.issue) begin
         raddr_d_ff <= rd_ptr_ff;
      end

      // handle the data of the previous read
      if (rvalid_ff) begin
         case (op_ff)
            alr_pkg::REQ_READ: begin
               rdata_ff <= mem_rd_data;
            end
            alr_pkg::REQ_FIND: begin
               if (match && !hit_ff) begin
                  hit_ff        <= 1'b1;
                  found_addr_ff <= raddr_d_ff;
               end
            end
            alr_pkg::REQ_REMOVE: begin
               if (match) begin
                  removed_ff <= removed_ff + CNT_W'(1);
               end else begin
                  wr_ptr_ff <= wr_ptr_ff + AW'(1);
               end
            end
            default: begin
               rdata_ff <= rdata_ff;
            end
         endcase
      end

      if (cmd.commit) begin
         rsp_status_ff    <= status_ff;
         rsp_read_data_ff <= rdata_ff;
         rsp_found_ff     <= hit_ff ? found_wide[OW-1:0] : {OW{1'b1}};
         rsp_length_ff    <= length_wide[OW-1:0];
         rsp_removed_ff   <= removed_out;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_read_data     = rsp_read_data_ff;
   assign rsp_found_index   = rsp_found_ff;
   assign rsp_list_length   = rsp_length_ff;
   assign rsp_removed_count = rsp_removed_ff;

endmodule

/* rtl/array_list_engine.sv */
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of signed 32-bit values held in a DEPTH-entry RAM.
// ----------------------------------------------------------------------------
// Sequence: start is taken in IDLE, then SETUP, one WALK step per entry walked,
//   DRAIN and DONE (commit); SETUP goes straight to DONE on an error or when L is 0.
//   L is the number of entries walked through the single RAM read port:
//   insert count-position, delete count-position-1, read 1, find/remove count.
// One request at a time: busy stays high until commit.
// Results cannot be stalled.
// Reset: clears the entry count and sequencer; RAM contents are not cleared.
module array_list_engine #(
   parameter int DEPTH = alr_pkg::DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [2:0]                        req_type,
   input  logic [alr_pkg::POS_W-1:0]         req_position,
   input  logic signed [alr_pkg::DATA_W-1:0] req_item_value,
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic signed [alr_pkg::DATA_W-1:0] rsp_read_data,
   output logic signed [alr_pkg::OUT_W-1:0]  rsp_found_index,
   output logic [alr_pkg::OUT_W-1:0]         rsp_list_length,
   output logic [alr_pkg::OUT_W-1:0]         rsp_removed_count
);

   localparam int AW = $clog2(DEPTH);

   alr_pkg::cmd_type  cmd;
   alr_pkg::stat_type stat;

   logic                       mem_wr_en;
   logic [AW-1:0]              mem_wr_addr;
   logic [alr_pkg::DATA_W-1:0] mem_wr_data;
   logic                       mem_rd_en;
   logic [AW-1:0]              mem_rd_addr;
   logic [alr_pkg::DATA_W-1:0] mem_rd_data;

   alr_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   alr_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_read_data     (rsp_read_data),
      .rsp_found_index   (rsp_found_index),
      .rsp_list_length   (rsp_list_length),
      .rsp_removed_count (rsp_removed_count)
   );

   alr_ram #(
      .WIDTH (alr_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for array_list_engine. A behavioral copy of the list
// predicts every result. Directed requests cover the empty list, both value
// extremes, out-of-range positions, unused request codes and a completely
// full store. Random traffic with bursty starts follows.
// ----------------------------------------------------------------------------
module tb;
   import alr_pkg::*;

   localparam int LIST_DEPTH  = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 8_000_000;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] read_data;
      logic signed [OUT_W-1:0]  found_index;
      logic [OUT_W-1:0]         list_length;
      logic [OUT_W-1:0]         removed_count;
   } list_result_type;

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     start          = 1'b0;
   logic [2:0]               req_type       = REQ_INSERT;
   logic [POS_W-1:0]         req_position   = '0;
   logic signed [DATA_W-1:0] req_item_value = '0;
   logic                     busy;
   logic                     rsp_valid;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_read_data;
   logic signed [OUT_W-1:0]  rsp_found_index;
   logic [OUT_W-1:0]         rsp_list_length;
   logic [OUT_W-1:0]         rsp_removed_count;

   logic signed [DATA_W-1:0] list_entries [LIST_DEPTH];
   int                       list_count  = 0;
   list_result_type          pending_results [$];
   list_result_type          due_result;
   int                       errors      = 0;
   int                       burst_left  = 0;
   int                       cycle_count = 0;

   array_list_engine #(.DEPTH(LIST_DEPTH)) DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_position      (req_position),
      .req_item_value    (req_item_value),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_read_data     (rsp_read_data),
      .rsp_found_index   (rsp_found_index),
      .rsp_list_length   (rsp_list_length),
      .rsp_removed_count (rsp_removed_count)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("array_list_engine test failed");
         $finish;
      end
   end

   // Apply one request to the list copy and return the result it produces.
   function automatic list_result_type apply_list_request(input logic [2:0] kind,
                                                          input logic [POS_W-1:0] pos,
                                                          input logic signed [DATA_W-1:0] value);
      list_result_type res;
      int p;
      int idx;
      int kept;
      int removed;
      bit hit;
      p                 = pos;
      removed           = 0;
      hit               = 1'b0;
      res.status        = ST_OK;
      res.read_data     = '0;
      res.found_index   = '1;
      case (kind)
         REQ_INSERT: begin
            if (p > list_count)
               res.status = ST_RANGE;
            else if (list_count >= LIST_DEPTH)
               res.status = ST_FULL;
            else begin
               for (idx = list_count; idx > p; idx--)
                  list_entries[idx] = list_entries[idx - 1];
               list_entries[p] = value;
               list_count++;
            end
         end
         REQ_DELETE: begin
            if (p >= list_count)
               res.status = ST_RANGE;
            else begin
               for (idx = p; idx + 1 < list_count; idx++)
                  list_entries[idx] = list_entries[idx + 1];
               list_count--;
               removed = 1;
            end
         end
         REQ_READ: begin
            if (p >= list_count)
               res.status = ST_RANGE;
            else
               res.read_data = list_entries[p];
         end
         REQ_FIND: begin
            for (idx = 0; idx < list_count && !hit; idx++) begin
               if (list_entries[idx] == value) begin
                  res.found_index = idx[OUT_W-1:0];
                  hit = 1'b1;
               end
            end
         end
         REQ_REMOVE: begin
            kept = 0;
            for (idx = 0; idx < list_count; idx++) begin
               if (list_entries[idx] == value)
                  removed++;
               else begin
                  list_entries[kept] = list_entries[idx];
                  kept++;
               end
            end
            list_count = kept;
         end
         default: ;
      endcase
      res.list_length   = list_count[OUT_W-1:0];
      res.removed_count = removed[OUT_W-1:0];
      return res;
   endfunction

   function automatic void compare_field(input string name,
                                         input logic signed [DATA_W:0] want,
                                         input logic signed [DATA_W:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with none expected: expected none, actual status %0d length %0d",
                     $time, rsp_status, rsp_list_length);
            errors++;
         end else begin
            due_result = pending_results.pop_front();
            compare_field("status", due_result.status, rsp_status);
            compare_field("read_data", due_result.read_data, rsp_read_data);
            compare_field("found_index", due_result.found_index, rsp_found_index);
            compare_field("list_length", due_result.list_length, rsp_list_length);
            compare_field("removed_count", due_result.removed_count, rsp_removed_count);
         end
      end
   end

   // Drive one request at the falling edge and hold it until the transfer.
   task automatic send_request(input logic [2:0] kind, input logic [POS_W-1:0] pos,
                               input logic signed [DATA_W-1:0] value);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left     = burst_left - 1;
      start          <= 1'b1;
      req_type       <= kind;
      req_position   <= pos;
      req_item_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(apply_list_request(kind, pos, value));
      @(negedge clock);
   endtask

   task automatic wait_results();
      start <= 1'b0;
      @(negedge clock);
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sd0;
         1:       return -32'sd1;
         2:       return 32'sd1;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h8000_0000;
         5:       return 32'h5555_5555;
         6:       return 32'hAAAA_AAAA;
         7:       return 32'sd5;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_small_list();
      send_request(REQ_READ, 0, 0);                 // empty list: range
      send_request(REQ_DELETE, 0, 0);
      send_request(REQ_FIND, 0, 7);
      send_request(REQ_REMOVE, 0, 7);
      send_request(REQ_INSERT, 1, 3);               // past end
      send_request(REQ_INSERT, '1, 3);
      send_request(REQ_REMOVE + 3'd1, '1, '1);      // unused codes
      send_request(REQ_REMOVE + 3'd2, '1, '1);
      send_request(REQ_REMOVE + 3'd3, '1, '1);
      send_request(REQ_INSERT, 0, 32'h8000_0000);
      send_request(REQ_INSERT, 1, 32'h7FFF_FFFF);
      send_request(REQ_INSERT, 0, 0);               // front
      send_request(REQ_INSERT, 2, -1);              // middle
      send_request(REQ_INSERT, 4, 0);               // end
      send_request(REQ_READ, 0, 0);
      send_request(REQ_READ, 4, 0);
      send_request(REQ_READ, 5, 0);
      send_request(REQ_READ, '1, 0);
      send_request(REQ_FIND, 0, 0);
      send_request(REQ_FIND, 0, 32'h7FFF_FFFF);
      send_request(REQ_DELETE, 1, 0);
      send_request(REQ_REMOVE, 0, 0);               // two copies go
      send_request(REQ_DELETE, 2, 0);
      send_request(REQ_DELETE, 0, 0);
      send_request(REQ_READ, 0, 0);
      wait_results();
   endtask

   task automatic test_full_store();
      int k;
      k = 0;
      while (list_count < LIST_DEPTH) begin
         case (k % 3)
            0:       send_request(REQ_INSERT, POS_W'(list_count), 32'h7FFF_FFFF);
            1:       send_request(REQ_INSERT, POS_W'(list_count), 32'h8000_0000);
            default: send_request(REQ_INSERT, POS_W'(list_count), 0);
         endcase
         k++;
      end
      send_request(REQ_INSERT, 0, 9);                           // full
      send_request(REQ_INSERT, POS_W'(LIST_DEPTH), 9);          // full
      send_request(REQ_INSERT, POS_W'(LIST_DEPTH + 1), 9);      // range wins
      send_request(REQ_READ, POS_W'(LIST_DEPTH - 1), 0);
      send_request(REQ_READ, POS_W'(LIST_DEPTH), 0);
      send_request(REQ_FIND, 0, 0);
      send_request(REQ_FIND, 0, 12345);                         // full walk, absent
      send_request(REQ_DELETE, 0, 0);
      send_request(REQ_INSERT, 0, -5);
      send_request(REQ_FIND, 0, -5);
      send_request(REQ_DELETE, POS_W'(LIST_DEPTH - 1), 0);
      send_request(REQ_REMOVE, 0, 32'h7FFF_FFFF);
      send_request(REQ_REMOVE, 0, 32'h8000_0000);
      send_request(REQ_REMOVE, 0, 0);
      send_request(REQ_REMOVE, 0, -5);
      send_request(REQ_READ, 0, 0);
      wait_results();
   endtask

   task automatic test_random_traffic(input int n_items);
      int                       k;
      int                       roll;
      int                       target;
      logic [2:0]               kind;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      target = 16;
      for (k = 0; k < n_items; k++) begin
         // drift the length the list hovers around
         if (k % 100 == 0) target = $urandom_range(2, 90);
         value = pick_value();
         pos   = POS_W'($urandom_range(0, 2047));
         roll  = $urandom_range(0, 99);
         if (roll < ((list_count < target) ? 45 : 12)) begin
            kind = REQ_INSERT;
            if ($urandom_range(0, 9) != 0) pos = POS_W'($urandom_range(0, list_count));
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 25)      kind = REQ_DELETE;
            else if (roll < 50) kind = REQ_READ;
            else if (roll < 75) kind = REQ_FIND;
            else if (roll < 93) kind = REQ_REMOVE;
            else                kind = REQ_REMOVE + 3'($urandom_range(1, 3));
            if ((kind == REQ_DELETE || kind == REQ_READ) && list_count > 0 &&
                $urandom_range(0, 9) != 0)
               pos = POS_W'($urandom_range(0, list_count - 1));
            if ((kind == REQ_FIND || kind == REQ_REMOVE) && list_count > 0 &&
                $urandom_range(0, 3) != 0)
               value = list_entries[$urandom_range(0, list_count - 1)];
         end
         send_request(kind, pos, value);
      end
      wait_results();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_small_list();
      test_full_store();
      test_random_traffic(580);
      // let any stray result show up
      repeat (LIST_DEPTH + 8) @(negedge clock);
      if (errors == 0 && pending_results.size() == 0)
         $display("array_list_engine test passed");
      else
         $display("array_list_engine test failed");
      $finish;
   end

endmodule

/* files.f */
rtl/alr_pkg.sv
rtl/alr_ram.sv
rtl/alr_ctrl.sv
rtl/alr_dpath.sv
rtl/array_list_engine.sv
test/tb.sv
